// File: rtl/dcm_pkg.sv
// shared types and constants for the directory record callsign matcher
package dcm_pkg;

    // longest callsign the target registers can describe
    localparam int unsigned MAX_CALL_BYTES  = 16;
    // longest usable callsign line, and address line including its newline
    localparam int unsigned MAX_FIELD_BYTES = 31;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_DOT     = 8'h2e;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // line and call lengths saturate here
    localparam logic [5:0] LEN_SAT = 6'd63;

    localparam logic [1:0] ACT_DATA       = 2'd0;
    localparam logic [1:0] ACT_DISCONNECT = 2'd1;
    localparam logic [1:0] ACT_FOREIGN    = 2'd2;
    localparam logic [1:0] ACT_RESTART    = 2'd3;

    localparam logic [1:0] PH_RECEIVING = 2'd0;
    localparam logic [1:0] PH_SUCCEEDED = 2'd1;
    localparam logic [1:0] PH_FAILED    = 2'd2;

    localparam logic [1:0] REG_CALL_LOW  = 2'd0;
    localparam logic [1:0] REG_CALL_HIGH = 2'd1;
    localparam logic [1:0] REG_CALL_LEN  = 2'd2;

    localparam logic [1:0] LINE_CALL = 2'd0;
    localparam logic [1:0] LINE_SKIP1 = 2'd1;
    localparam logic [1:0] LINE_SKIP2 = 2'd2;
    localparam logic [1:0] LINE_ADDR = 2'd3;

    typedef struct packed {
        logic [63:0] call_low;
        logic [63:0] call_high;
        logic [4:0]  call_len;
    } dcm_cfg_t;

    typedef struct packed {
        logic        done_res;
        logic        success;
        logic        found;
        logic [31:0] address;
    } dcm_status_t;

endpackage

// File: rtl/dcm_parser.sv
// lookup state and per-byte update logic of the callsign matcher
module dcm_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [1:0]           action,
    input  logic [7:0]           data_byte,
    input  dcm_pkg::dcm_cfg_t    cfg,
    output dcm_pkg::dcm_status_t status_next
);

    logic [1:0]  phase_reg,       phase_next;
    logic        header_seen_reg, header_seen_next;
    logic [1:0]  line_index_reg,  line_index_next;
    logic [5:0]  call_pos_reg,    call_pos_next;
    logic        call_mm_reg,     call_mm_next;
    logic [5:0]  ip_len_reg,      ip_len_next;
    logic [7:0]  octet_acc_reg,   octet_acc_next;
    logic [1:0]  octet_idx_reg,   octet_idx_next;
    logic [31:0] ip_partial_reg,  ip_partial_next;
    logic        found_reg,       found_next;
    logic [31:0] found_addr_reg,  found_addr_next;

    logic [4:0]   eff_len;
    logic [127:0] target;
    logic [7:0]   target_byte;
    logic         is_newline;
    logic         is_digit;
    logic [7:0]   digit;
    logic [5:0]   ip_len_inc;
    logic [31:0]  ip_stored;
    logic         call_ok;

    always_comb
    begin
        eff_len = (cfg.call_len > 5'(dcm_pkg::MAX_CALL_BYTES))
                  ? 5'(dcm_pkg::MAX_CALL_BYTES) : cfg.call_len;
        target  = {cfg.call_high, cfg.call_low};
        // positions past the register pair read as zero
        target_byte = (call_pos_reg < 6'd16) ? target[{call_pos_reg[3:0], 3'b000} +: 8] : 8'h00;
        is_newline  = (data_byte == dcm_pkg::CHAR_NEWLINE);
        is_digit    = (data_byte >= dcm_pkg::CHAR_ZERO) && (data_byte <= dcm_pkg::CHAR_NINE);
        digit       = data_byte - dcm_pkg::CHAR_ZERO;
        ip_len_inc  = (ip_len_reg < dcm_pkg::LEN_SAT) ? ip_len_reg + 6'd1 : ip_len_reg;
        ip_stored   = ip_partial_reg
                    | ({24'd0, octet_acc_reg} << {~octet_idx_reg, 3'b000});
        call_ok     = !call_mm_reg && (call_pos_reg == {1'b0, eff_len})
                    && (call_pos_reg <= 6'(dcm_pkg::MAX_FIELD_BYTES));

        phase_next       = phase_reg;
        header_seen_next = header_seen_reg;
        line_index_next  = line_index_reg;
        call_pos_next    = call_pos_reg;
        call_mm_next     = call_mm_reg;
        ip_len_next      = ip_len_reg;
        octet_acc_next   = octet_acc_reg;
        octet_idx_next   = octet_idx_reg;
        ip_partial_next  = ip_partial_reg;
        found_next       = found_reg;
        found_addr_next  = found_addr_reg;

        if (action == dcm_pkg::ACT_RESTART)
        begin
            phase_next       = dcm_pkg::PH_RECEIVING;
            header_seen_next = 1'b0;
            line_index_next  = dcm_pkg::LINE_CALL;
            call_pos_next    = 6'd0;
            call_mm_next     = 1'b0;
            ip_len_next      = 6'd0;
            octet_acc_next   = 8'd0;
            octet_idx_next   = 2'd0;
            ip_partial_next  = 32'd0;
            found_next       = 1'b0;
            found_addr_next  = 32'd0;
        end
        else if (phase_reg == dcm_pkg::PH_RECEIVING)
        begin
            unique case (action)
                dcm_pkg::ACT_DISCONNECT:
                begin
                    phase_next = found_reg ? dcm_pkg::PH_SUCCEEDED : dcm_pkg::PH_FAILED;
                end
                dcm_pkg::ACT_FOREIGN:
                begin
                    phase_next = dcm_pkg::PH_FAILED;
                end
                default:
                begin
                    if (found_reg)
                    begin
                        // bytes after a match are dropped
                    end
                    else if (!header_seen_reg)
                    begin
                        if (is_newline)
                        begin
                            if (line_index_reg == dcm_pkg::LINE_SKIP1)
                            begin
                                header_seen_next = 1'b1;
                                line_index_next  = dcm_pkg::LINE_CALL;
                            end
                            else
                            begin
                                line_index_next = dcm_pkg::LINE_SKIP1;
                            end
                        end
                    end
                    else
                    begin
                        unique case (line_index_reg)
                            dcm_pkg::LINE_CALL:
                            begin
                                if (is_newline)
                                begin
                                    call_mm_next    = !call_ok;
                                    line_index_next = dcm_pkg::LINE_SKIP1;
                                end
                                else
                                begin
                                    if ((call_pos_reg >= {1'b0, eff_len})
                                        || (target_byte != data_byte))
                                    begin
                                        call_mm_next = 1'b1;
                                    end
                                    if (call_pos_reg < dcm_pkg::LEN_SAT)
                                    begin
                                        call_pos_next = call_pos_reg + 6'd1;
                                    end
                                end
                            end
                            dcm_pkg::LINE_SKIP1, dcm_pkg::LINE_SKIP2:
                            begin
                                if (is_newline)
                                begin
                                    line_index_next = line_index_reg + 2'd1;
                                end
                            end
                            default:
                            begin
                                ip_len_next = ip_len_inc;
                                if (is_newline)
                                begin
                                    if (!call_mm_reg
                                        && (ip_len_inc <= 6'(dcm_pkg::MAX_FIELD_BYTES)))
                                    begin
                                        found_next      = 1'b1;
                                        found_addr_next = ip_stored;
                                    end
                                    line_index_next = dcm_pkg::LINE_CALL;
                                    call_pos_next   = 6'd0;
                                    call_mm_next    = 1'b0;
                                    ip_len_next     = 6'd0;
                                    octet_acc_next  = 8'd0;
                                    octet_idx_next  = 2'd0;
                                    ip_partial_next = 32'd0;
                                end
                                else if (is_digit)
                                begin
                                    // acc * 10 + digit, kept modulo 256
                                    octet_acc_next = (octet_acc_reg << 3) + (octet_acc_reg << 1)
                                                   + digit;
                                end
                                else if (data_byte == dcm_pkg::CHAR_DOT)
                                begin
                                    if (octet_idx_reg != 2'd3)
                                    begin
                                        ip_partial_next = ip_stored;
                                        octet_idx_next  = octet_idx_reg + 2'd1;
                                        octet_acc_next  = 8'd0;
                                    end
                                end
                            end
                        endcase
                    end
                end
            endcase
        end

        status_next.done_res = (phase_next != dcm_pkg::PH_RECEIVING);
        status_next.success  = (phase_next == dcm_pkg::PH_SUCCEEDED);
        status_next.found    = found_next;
        status_next.address  = found_addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= dcm_pkg::PH_RECEIVING;
            header_seen_reg <= 1'b0;
            line_index_reg  <= dcm_pkg::LINE_CALL;
            call_pos_reg    <= 6'd0;
            call_mm_reg     <= 1'b0;
            ip_len_reg      <= 6'd0;
            octet_acc_reg   <= 8'd0;
            octet_idx_reg   <= 2'd0;
            ip_partial_reg  <= 32'd0;
            found_reg       <= 1'b0;
            found_addr_reg  <= 32'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            header_seen_reg <= header_seen_next;
            line_index_reg  <= line_index_next;
            call_pos_reg    <= call_pos_next;
            call_mm_reg     <= call_mm_next;
            ip_len_reg      <= ip_len_next;
            octet_acc_reg   <= octet_acc_next;
            octet_idx_reg   <= octet_idx_next;
            ip_partial_reg  <= ip_partial_next;
            found_reg       <= found_next;
            found_addr_reg  <= found_addr_next;
        end
    end

endmodule

// File: rtl/directory_record_callsign_matcher_unit.sv
// top level: configuration registers, input handshake and result register
//
// Each accepted transfer (a directory byte, a disconnect, a foreign event or a restart) updates the
// lookup state in one pass of logic and loads one status result into the output
// register, which shows it from the next cycle on. One transfer is accepted per
// cycle; the input stalls only while the output register holds a result that has
// not been taken, so throughput is one item per clock while results are taken.
module directory_record_callsign_matcher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        done_res,
    output logic        success,
    output logic        found,
    output logic [31:0] address
);

    dcm_pkg::dcm_cfg_t    cfg_reg;
    dcm_pkg::dcm_status_t status_next;
    dcm_pkg::dcm_status_t result_reg;
    logic                 out_valid_reg;
    logic                 step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    dcm_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .action      (action),
        .data_byte   (data_byte),
        .cfg         (cfg_reg),
        .status_next (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.call_low  <= 64'd0;
            cfg_reg.call_high <= 64'd0;
            cfg_reg.call_len  <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dcm_pkg::REG_CALL_LOW:  cfg_reg.call_low  <= cfg_data;
                dcm_pkg::REG_CALL_HIGH: cfg_reg.call_high <= cfg_data;
                dcm_pkg::REG_CALL_LEN:  cfg_reg.call_len  <= cfg_data[4:0];
                default:
                begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign done_res  = result_reg.done_res;
    assign success   = result_reg.success;
    assign found     = result_reg.found;
    assign address   = result_reg.address;

endmodule

// File: bench/directory_record_callsign_matcher_checker.sv
// scoreboard for the callsign matcher: watches both channels, predicts each status and compares
module directory_record_callsign_matcher_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        done_res,
    input  logic        success,
    input  logic        found,
    input  logic [31:0] address,
    output int          mismatches,
    output int          awaiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import dcm_pkg::*;

    // target callsign as last written
    logic [63:0] want_low;
    logic [63:0] want_high;
    logic [4:0]  want_len;

    // lookup state
    logic [1:0]  lookup_phase;
    logic        header_done;
    logic [1:0]  line_no;
    logic [5:0]  call_pos;
    logic        call_bad;
    logic [5:0]  addr_len;
    logic [7:0]  octet_acc;
    logic [1:0]  octet_slot;
    logic [31:0] addr_work;
    logic        match_seen;
    logic [31:0] match_addr;

    dcm_status_t pending_status[$];

    task automatic report_mismatch(input string what);
        $display("%0t checker: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_lookup();
        lookup_phase = PH_RECEIVING;
        header_done  = 1'b0;
        line_no      = LINE_CALL;
        call_pos     = '0;
        call_bad     = 1'b0;
        addr_len     = '0;
        octet_acc    = '0;
        octet_slot   = '0;
        addr_work    = '0;
        match_seen   = 1'b0;
        match_addr   = '0;
    endtask

    function automatic logic [5:0] call_limit();
        return (want_len > MAX_CALL_BYTES) ? 6'(MAX_CALL_BYTES) : 6'(want_len);
    endfunction

    function automatic logic [7:0] wanted_byte(input logic [5:0] pos);
        if (pos < 6'd8)
            return want_low[{pos[2:0], 3'b000} +: 8];
        else if (pos < 6'd16)
            return want_high[{pos[2:0], 3'b000} +: 8];
        return 8'h00;
    endfunction

    task automatic store_octet();
        addr_work[8 * (3 - octet_slot) +: 8] = addr_work[8 * (3 - octet_slot) +: 8] | octet_acc;
    endtask

    task automatic take_directory_byte(input logic [7:0] b);
        logic ok;
        if (!header_done)
        begin
            // header: line_no marks that its first newline went by
            if (b == CHAR_NEWLINE)
            begin
                if (line_no == LINE_SKIP1)
                begin
                    header_done = 1'b1;
                    line_no = LINE_CALL;
                end
                else
                    line_no = LINE_SKIP1;
            end
        end
        else
        begin
            case (line_no)
                LINE_CALL:
                begin
                    if (b == CHAR_NEWLINE)
                    begin
                        ok = !call_bad && call_pos == call_limit()
                             && call_pos <= MAX_FIELD_BYTES;
                        call_bad = !ok;
                        line_no = LINE_SKIP1;
                    end
                    else
                    begin
                        if (call_pos >= call_limit() || wanted_byte(call_pos) != b)
                            call_bad = 1'b1;
                        if (call_pos < LEN_SAT)
                            call_pos = call_pos + 6'd1;
                    end
                end
                LINE_SKIP1, LINE_SKIP2:
                begin
                    if (b == CHAR_NEWLINE)
                        line_no = line_no + 2'd1;
                end
                default:
                begin
                    if (addr_len < LEN_SAT)
                        addr_len = addr_len + 6'd1;
                    if (b == CHAR_NEWLINE)
                    begin
                        store_octet();
                        if (!call_bad && addr_len <= MAX_FIELD_BYTES)
                        begin
                            match_seen = 1'b1;
                            match_addr = addr_work;
                        end
                        line_no    = LINE_CALL;
                        call_pos   = '0;
                        call_bad   = 1'b0;
                        addr_len   = '0;
                        octet_acc  = '0;
                        octet_slot = '0;
                        addr_work  = '0;
                    end
                    else if (b >= CHAR_ZERO && b <= CHAR_NINE)
                        octet_acc = octet_acc * 8'd10 + (b - CHAR_ZERO);
                    else if (b == CHAR_DOT && octet_slot < 2'd3)
                    begin
                        store_octet();
                        octet_slot = octet_slot + 2'd1;
                        octet_acc = '0;
                    end
                end
            endcase
        end
    endtask

    task automatic predict_status(input logic [1:0] act, input logic [7:0] b,
                                  output dcm_status_t status);
        if (act == ACT_RESTART)
            clear_lookup();
        else if (lookup_phase == PH_RECEIVING)
        begin
            if (act == ACT_DATA)
            begin
                if (!match_seen)
                    take_directory_byte(b);
            end
            else if (act == ACT_DISCONNECT)
                lookup_phase = match_seen ? PH_SUCCEEDED : PH_FAILED;
            else
                lookup_phase = PH_FAILED;
        end
        status.done_res = lookup_phase != PH_RECEIVING;
        status.success  = lookup_phase == PH_SUCCEEDED;
        status.found    = match_seen;
        status.address  = match_addr;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dcm_status_t want;
        dcm_status_t next_status;
        if (!rst_n)
        begin
            want_low  = '0;
            want_high = '0;
            want_len  = 5'd1;
            clear_lookup();
            pending_status.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CALL_LOW:  want_low  = cfg_data;
                    REG_CALL_HIGH: want_high = cfg_data;
                    REG_CALL_LEN:  want_len  = cfg_data[4:0];
                    default: ;
                endcase
            end
            // compare before pushing so a same-edge input never pairs with this output
            if (out_valid && out_ready)
            begin
                if (pending_status.size() == 0)
                    report_mismatch("status transfer with no prediction waiting");
                else
                begin
                    want = pending_status.pop_front();
                    if (done_res !== want.done_res)
                        report_mismatch($sformatf("done_res expected %0b got %0b",
                                                  want.done_res, done_res));
                    if (success !== want.success)
                        report_mismatch($sformatf("success expected %0b got %0b",
                                                  want.success, success));
                    if (found !== want.found)
                        report_mismatch($sformatf("found expected %0b got %0b",
                                                  want.found, found));
                    if (address !== want.address)
                        report_mismatch($sformatf("address expected %h got %h",
                                                  want.address, address));
                end
            end
            if (in_valid && in_ready)
            begin
                predict_status(action, data_byte, next_status);
                pending_status.push_back(next_status);
            end
        end
        awaiting = pending_status.size();
    end

endmodule

// File: bench/directory_record_callsign_matcher_unit_test.sv
// top of the callsign matcher bench: clock, reset, directory stimulus and the verdict
module directory_record_callsign_matcher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dcm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned ITEM_GOAL   = 950;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam logic [7:0]  CHAR_RETURN = 8'h0d;

    typedef enum int {CALL_MATCH, CALL_SHORT, CALL_EXTRA, CALL_ALTERED, CALL_NOISE, CALL_LONG}
        call_shape_e;
    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] b;
    } dir_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic        done_res;
    logic        success;
    logic        found;
    logic [31:0] address;
    int          mismatches;
    int          awaiting;

    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    bit          hold_request   = 1'b0;
    int          items_sent     = 0;

    // target as programmed, used to build matching lines
    logic [7:0]  call_text[16];
    logic [4:0]  call_len;

    dir_item_t   script[$];

    directory_record_callsign_matcher_unit dut (.*);

    directory_record_callsign_matcher_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when asked
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                out_ready <= !receiver_idles || $urandom_range(0, 99) >= 20;
        end
    end

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_NEWLINE)
            b = CHAR_RETURN;
        return b;
    endfunction

    function automatic void put(input logic [1:0] act, input logic [7:0] b);
        script.push_back({act, b});
    endfunction

    function automatic void put_filler_line(input int longest);
        repeat ($urandom_range(0, longest)) put(ACT_DATA, text_byte());
        put(ACT_DATA, CHAR_NEWLINE);
    endfunction

    function automatic void put_call_line(input call_shape_e shape);
        int span;
        int flip;
        logic [7:0] twist;
        span = (call_len > MAX_CALL_BYTES) ? MAX_CALL_BYTES : int'(call_len);
        case (shape)
            CALL_MATCH:
                for (int i = 0; i < span; i++) put(ACT_DATA, call_text[i]);
            CALL_SHORT:
                for (int i = 0; i + 1 < span; i++) put(ACT_DATA, call_text[i]);
            CALL_EXTRA:
            begin
                for (int i = 0; i < span; i++) put(ACT_DATA, call_text[i]);
                put(ACT_DATA, text_byte());
            end
            CALL_ALTERED:
            begin
                if (span == 0)
                    put(ACT_DATA, text_byte());
                else
                begin
                    flip = $urandom_range(0, span - 1);
                    twist = call_text[flip] ^ 8'($urandom_range(1, 255));
                    if (twist == CHAR_NEWLINE)
                        twist = call_text[flip] ^ 8'h01;
                    if (twist == CHAR_NEWLINE)
                        twist = call_text[flip] ^ 8'h02;
                    for (int i = 0; i < span; i++)
                        put(ACT_DATA, (i == flip) ? twist : call_text[i]);
                end
            end
            CALL_NOISE:
                repeat ($urandom_range(0, 20)) put(ACT_DATA, text_byte());
            default:
                repeat ($urandom_range(28, 70)) put(ACT_DATA, text_byte());
        endcase
        put(ACT_DATA, CHAR_NEWLINE);
    endfunction

    function automatic void put_address_line(input bit near_limit);
        logic [7:0] body[$];
        int octets;
        int padded_to;
        octets = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 4;
        for (int k = 0; k < octets; k++)
        begin
            if (k > 0)
                body.push_back(CHAR_DOT);
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 3))
                body.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 15) == 0)
                body.push_back(text_byte());
        end
        if ($urandom_range(0, 7) == 0)
            body.push_back(CHAR_RETURN);
        // leading zeros stretch the line around the length limit without changing the value
        case ($urandom_range(0, 7))
            0: padded_to = $urandom_range(30, 33);
            1: padded_to = $urandom_range(60, 70);
            default: padded_to = 0;
        endcase
        if (near_limit)
            padded_to = $urandom_range(30, 33);
        while (body.size() + 1 < padded_to)
            body.push_front(CHAR_ZERO);
        foreach (body[i]) put(ACT_DATA, body[i]);
        put(ACT_DATA, CHAR_NEWLINE);
    endfunction

    // one whole lookup: restart, header, records, disconnect or foreign end, then a few ignored items
    function automatic void put_lookup(input int records);
        call_shape_e shape;
        put(ACT_RESTART, 8'($urandom()));
        put_filler_line(6);
        put_filler_line(6);
        repeat (records)
        begin
            if ($urandom_range(0, 2) == 0)
                shape = CALL_MATCH;
            else
                shape = call_shape_e'($urandom_range(1, 5));
            put_call_line(shape);
            put_filler_line(4);
            put_filler_line(4);
            put_address_line(shape == CALL_MATCH && $urandom_range(0, 1) == 1);
        end
        put(($urandom_range(0, 3) == 0) ? ACT_FOREIGN : ACT_DISCONNECT, 8'($urandom()));
        repeat ($urandom_range(0, 4)) put(2'($urandom_range(0, 2)), 8'($urandom()));
    endfunction

    function automatic void put_noise(input int count);
        int roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                put(ACT_DISCONNECT, 8'($urandom()));
            else if (roll < 9)
                put(ACT_FOREIGN, 8'($urandom()));
            else if (roll < 15)
                put(ACT_RESTART, 8'($urandom()));
            else if (roll < 45)
                put(ACT_DATA, CHAR_NEWLINE);
            else
                put(ACT_DATA, 8'($urandom()));
        end
    endfunction

    task automatic send_item(input dir_item_t item);
        if (sender_idles && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= item.act;
        data_byte <= item.b;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic play_script();
        while (script.size() > 0)
            send_item(script.pop_front());
    endtask

    // stop offering and wait until every predicted status has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic program_target(input logic [4:0] len, input fill_e fill);
        logic [63:0] low;
        logic [63:0] high;
        for (int i = 0; i < 16; i++)
        begin
            case (fill)
                FILL_ONES:  call_text[i] = 8'hff;
                FILL_ZEROS: call_text[i] = 8'h00;
                default:    call_text[i] = text_byte();
            endcase
        end
        for (int i = 0; i < 8; i++)
        begin
            low[8 * i +: 8]  = call_text[i];
            high[8 * i +: 8] = call_text[i + 8];
        end
        call_len = len;
        cfg_we    <= 1'b1;
        cfg_index <= REG_CALL_LOW;
        cfg_data  <= low;
        @(posedge clk);
        cfg_index <= REG_CALL_HIGH;
        cfg_data  <= high;
        @(posedge clk);
        cfg_index <= REG_CALL_LEN;
        cfg_data  <= {59'($urandom()) << 27 | 59'($urandom()), len};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_CALL_LOW;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        action    <= ACT_DATA;
        data_byte <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset target is one zero byte
        put(ACT_DISCONNECT, 8'h00);
        put(ACT_DATA, 8'hff);
        put(ACT_FOREIGN, 8'hff);
        put(ACT_RESTART, 8'h00);
        put(ACT_DATA, 8'h00);
        put(ACT_DATA, CHAR_NEWLINE);
        put(ACT_DATA, CHAR_NEWLINE);
        put(ACT_DATA, 8'h00);
        put(ACT_DATA, CHAR_NEWLINE);
        put(ACT_DATA, CHAR_NEWLINE);
        put(ACT_DATA, CHAR_NEWLINE);
        // "255.999" with a carriage return: second octet wraps, the rest stay zero
        put(ACT_DATA, CHAR_ZERO + 8'd2);
        put(ACT_DATA, CHAR_ZERO + 8'd5);
        put(ACT_DATA, CHAR_ZERO + 8'd5);
        put(ACT_DATA, CHAR_DOT);
        put(ACT_DATA, CHAR_NINE);
        put(ACT_DATA, CHAR_NINE);
        put(ACT_DATA, CHAR_NINE);
        put(ACT_DATA, CHAR_RETURN);
        put(ACT_DATA, CHAR_NEWLINE);
        put(ACT_DISCONNECT, 8'h00);
        put(ACT_DATA, CHAR_NEWLINE);
        put(ACT_RESTART, 8'hff);
        put(ACT_FOREIGN, 8'h00);
        put(ACT_RESTART, 8'h00);
        play_script();
        drain();

        for (int p = 1; items_sent < ITEM_GOAL; p++)
        begin
            case (p)
                1: program_target(5'd16, FILL_ONES);
                2: program_target(5'd0, FILL_RANDOM);
                3: program_target(5'd31, FILL_RANDOM);
                4: program_target(5'd17, FILL_ZEROS);
                5: program_target(5'd1, FILL_RANDOM);
                default:
                    program_target(($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                                : 5'($urandom_range(1, 16)),
                                   FILL_RANDOM);
            endcase
            // one phase runs with no stalls at all on either side
            sender_idles   = (p != 2);
            receiver_idles = (p != 2);
            if (p % 3 == 0)
                hold_request = 1'b1;
            if (p % 4 == 0)
            begin
                // a lookup broken off part way, then noise
                put_lookup(3);
                while (script.size() > $urandom_range(5, 60))
                    void'(script.pop_back());
                put_noise(40);
            end
            else
                put_lookup($urandom_range(1, 4));
            play_script();
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
